// ===== hw/rtl/sky_map_weighted_sampler_macros.svh =====
// ----------------------------------------------------------------------------
// Sky map sampler assertion macros
// Concurrent assertion helpers shared by the sampler RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SKY_MAP_WEIGHTED_SAMPLER_MACROS_SVH
`define SKY_MAP_WEIGHTED_SAMPLER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is high.
`define SMWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sampler assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SMWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sampler assertion failed");

`else

`define SMWS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SMWS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/smws_pkg.sv =====
// ----------------------------------------------------------------------------
// Sky map sampler package
// Payload types, fixed widths and the latitude cosine table.
// ----------------------------------------------------------------------------
`default_nettype none

package smws_pkg;

  localparam int MUL_W    = 24;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int TOTAL_W  = 48;
  localparam int DRAW_W   = 24;
  localparam int COS_W    = 16;
  localparam int INT_W    = 16;
  localparam int THRESH_W = TOTAL_W + 1;

  localparam logic [8:0] LON_OFFSET = 9'd180;
  localparam logic [7:0] LAT_OFFSET = 8'd90;
  localparam logic [9:0] EQUATOR    = 10'd90;
  localparam logic [9:0] POLE_DIST  = 10'd90;

  localparam logic [0:0] ACT_WRITE  = 1'b0;
  localparam logic [0:0] ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic [0:0]        action;
    logic [8:0]        lon_cell;
    logic [7:0]        lat_cell;
    logic [INT_W-1:0]  cell_intensity;
    logic [7:0]        cell_spectral_index;
    logic [DRAW_W-1:0] uniform_draw;
  } smws_item_t;

  typedef struct packed {
    logic signed [8:0] lon_deg;
    logic signed [7:0] lat_deg;
    logic [7:0]        chosen_index;
    logic [0:0]        map_empty;
  } smws_result_t;

  // round(65536 * cos(d degrees)) for d = 0..90, with the first entry saturated.
  localparam logic [COS_W-1:0] COS_ROM [0:90] = '{
    16'd65535, 16'd65526, 16'd65496, 16'd65446, 16'd65376, 16'd65287, 16'd65177,
    16'd65048, 16'd64898, 16'd64729, 16'd64540, 16'd64332, 16'd64104, 16'd63856,
    16'd63589, 16'd63303, 16'd62997, 16'd62672, 16'd62328, 16'd61966, 16'd61584,
    16'd61183, 16'd60764, 16'd60326, 16'd59870, 16'd59396, 16'd58903, 16'd58393,
    16'd57865, 16'd57319, 16'd56756, 16'd56175, 16'd55578, 16'd54963, 16'd54332,
    16'd53684, 16'd53020, 16'd52339, 16'd51643, 16'd50931, 16'd50203, 16'd49461,
    16'd48703, 16'd47930, 16'd47143, 16'd46341, 16'd45525, 16'd44695, 16'd43852,
    16'd42995, 16'd42126, 16'd41243, 16'd40348, 16'd39441, 16'd38521, 16'd37590,
    16'd36647, 16'd35693, 16'd34729, 16'd33754, 16'd32768, 16'd31772, 16'd30767,
    16'd29753, 16'd28729, 16'd27697, 16'd26656, 16'd25607, 16'd24550, 16'd23486,
    16'd22415, 16'd21336, 16'd20252, 16'd19161, 16'd18064, 16'd16962, 16'd15855,
    16'd14742, 16'd13626, 16'd12505, 16'd11380, 16'd10252, 16'd9121,  16'd7987,
    16'd6850,  16'd5712,  16'd4572,  16'd3430,  16'd2287,  16'd1144,  16'd0
  };

  // Cosine weight of a latitude cell; cells more than 90 degrees from the equator weigh nothing.
  function automatic logic [COS_W-1:0] lat_cos(input logic [9:0] lat);
    logic [9:0]       lat_off;
    logic [COS_W-1:0] w;
    lat_off = (lat >= EQUATOR) ? (lat - EQUATOR) : (EQUATOR - lat);
    if (lat_off > POLE_DIST) begin
      w = '0;
    end else begin
      w = COS_ROM[lat_off[6:0]];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/smws_stream_if.sv =====
// ----------------------------------------------------------------------------
// Sky map sampler stream interface
// Valid/ready channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface smws_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/smws_ram.sv =====
// ----------------------------------------------------------------------------
// Sky map sampler RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/smws_mul.sv =====
// ----------------------------------------------------------------------------
// Sky map sampler multiplier
// Shared 24 x 24 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module smws_mul (
  input  logic                        clk,
  input  logic [smws_pkg::MUL_W-1:0]  a,
  input  logic [smws_pkg::MUL_W-1:0]  b,
  output logic [smws_pkg::PROD_W-1:0] prod
);

  import smws_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sky_map_weighted_sampler.sv =====
// ----------------------------------------------------------------------------
// Sky map weighted sampler
// Cell store, running weight total and inverse-CDF walk over a sky grid.
// ----------------------------------------------------------------------------
// The block keeps a LON_CELLS x LAT_CELLS grid of cell intensities and spectral
// indices in one RAM, plus a running total of all cell weights, where a weight
// is the intensity times the cosine of the cell's latitude. A write item
// (action 0) stores one cell and gives no result; writes outside the grid
// are dropped. A sample item (action 1) scales the Q0.24 draw by the total
// to form a threshold and walks the cells longitude-major, one RAM read per
// cycle, through the shared multiplier and an accumulator, returning the first
// cell whose running sum exceeds the threshold. A sample's time grows with
// the walk-order position of its chosen cell, since the single RAM read port
// serves the walk. With a zero total the sample skips the walk and its answer,
// with map_empty set, goes from the done state to the output register. After
// reset the block clears all LON_CELLS * LAT_CELLS RAM entries (64800 at the
// default sizes), one entry per cycle, before it takes the first item.
// A finished result waits in an output register, so write items keep flowing
// while it is not yet taken.
`default_nettype none
`include "sky_map_weighted_sampler_macros.svh"

module sky_map_weighted_sampler #(
  parameter int LON_CELLS      = 360,
  parameter int LAT_CELLS      = 180,
  parameter int INTENSITY_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  smws_stream_if.sink   item,
  smws_stream_if.source result
);

  import smws_pkg::*;

  localparam int GRID     = LON_CELLS * LAT_CELLS;
  localparam int ADDR_W   = $clog2(GRID);
  localparam int LON_W    = $clog2(LON_CELLS);
  localparam int LAT_W    = $clog2(LAT_CELLS);
  localparam int STORE_W  = (INTENSITY_BITS < INT_W) ? INTENSITY_BITS : INT_W;
  localparam int WPROD_W  = STORE_W + COS_W;
  localparam int ACC_W    = WPROD_W + ADDR_W;
  localparam int CMP_W    = (ACC_W > THRESH_W) ? ACC_W : THRESH_W;
  localparam int RAM_W    = STORE_W + 8;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(GRID - 1);
  localparam logic [LAT_W-1:0]  LAT_LAST  = LAT_W'(LAT_CELLS - 1);
  localparam logic [10:0]       LON_LIMIT = 11'(LON_CELLS);
  localparam logic [10:0]       LAT_LIMIT = 11'(LAT_CELLS);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_W_ADDR,
    S_W_READ,
    S_W_OLD,
    S_W_NEW,
    S_W_SUM,
    S_LO,
    S_HI,
    S_TH,
    S_WALK,
    S_DONE
  } state_t;

  state_t state;

  // Latched item and write-path registers.
  smws_item_t        it;
  logic [ADDR_W-1:0] wr_addr;
  logic [COS_W-1:0]  wr_cos;

  // Running total and sample threshold.
  logic [TOTAL_W-1:0]  total_weight;
  logic [DRAW_W-1:0]   lo_part;
  logic [THRESH_W-1:0] thresh;

  // Walk counters and pipeline. Stage 1 holds the RAM read data, stage 2 the
  // product from the shared multiplier.
  logic [ADDR_W-1:0] scan_addr;
  logic [LON_W-1:0]  lon_cnt;
  logic [LAT_W-1:0]  lat_cnt;
  logic              issue_active;
  logic              p1_valid;
  logic [LON_W-1:0]  p1_lon;
  logic [LAT_W-1:0]  p1_lat;
  logic [COS_W-1:0]  p1_cos;
  logic              p2_valid;
  logic [LON_W-1:0]  p2_lon;
  logic [LAT_W-1:0]  p2_lat;
  logic [7:0]        p2_index;
  logic [CMP_W-1:0]  acc;

  // Pending answer and output register.
  smws_result_t res;
  smws_result_t result_q;
  logic         result_valid;

  // RAM and multiplier hookup.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;

  logic [CMP_W-1:0] acc_sum;
  logic             crossed;
  logic             wr_in_grid;

  assign item.ready     = (state == S_IDLE);
  assign result.valid   = result_valid;
  assign result.payload = result_q;

  assign wr_in_grid = (11'(it.lon_cell) < LON_LIMIT) && (11'(it.lat_cell) < LAT_LIMIT);

  // Accumulate the weight in stage 2 and check for the crossing.
  assign acc_sum = acc + CMP_W'(mul_prod[WPROD_W-1:0]);
  assign crossed = p2_valid && (acc_sum > CMP_W'(thresh));

  // RAM port control: the clearing pass and the write path use the write port,
  // the write path's old-value read and the walk use the read port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = scan_addr;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_W_READ: begin
        ram_re    = 1'b1;
        ram_raddr = wr_addr;
      end
      S_W_OLD: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr;
        ram_wdata = {it.cell_spectral_index, it.cell_intensity[STORE_W-1:0]};
      end
      S_WALK: begin
        ram_re = issue_active;
      end
      default: begin
      end
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_W_OLD: begin
        mul_a = MUL_W'(ram_rdata[STORE_W-1:0]);
        mul_b = MUL_W'(wr_cos);
      end
      S_W_NEW: begin
        mul_a = MUL_W'(it.cell_intensity[STORE_W-1:0]);
        mul_b = MUL_W'(wr_cos);
      end
      S_LO: begin
        mul_a = total_weight[MUL_W-1:0];
        mul_b = it.uniform_draw;
      end
      S_HI: begin
        mul_a = total_weight[TOTAL_W-1:MUL_W];
        mul_b = it.uniform_draw;
      end
      S_WALK: begin
        mul_a = MUL_W'(ram_rdata[STORE_W-1:0]);
        mul_b = MUL_W'(p1_cos);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan_addr    <= '0;
      total_weight <= '0;
      issue_active <= 1'b0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result.ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_addr == ADDR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            it <= item.payload;
            if (item.payload.action == ACT_WRITE) begin
              state <= S_W_ADDR;
            end else if (total_weight == '0) begin
              res   <= '{lon_deg: '0, lat_deg: '0, chosen_index: '0, map_empty: 1'b1};
              state <= S_DONE;
            end else begin
              state <= S_LO;
            end
          end
        end
        S_W_ADDR: begin
          wr_addr <= ADDR_W'(ADDR_W'(it.lon_cell) * ADDR_W'(LAT_CELLS))
                     + ADDR_W'(it.lat_cell);
          wr_cos  <= lat_cos(10'(it.lat_cell));
          state   <= wr_in_grid ? S_W_READ : S_IDLE;
        end
        S_W_READ: begin
          state <= S_W_OLD;
        end
        S_W_OLD: begin
          state <= S_W_NEW;
        end
        S_W_NEW: begin
          // Old weight leaves the total here, the new one joins next cycle.
          total_weight <= total_weight - mul_prod[TOTAL_W-1:0];
          state        <= S_W_SUM;
        end
        S_W_SUM: begin
          total_weight <= total_weight + mul_prod[TOTAL_W-1:0];
          state        <= S_IDLE;
        end
        S_LO: begin
          state <= S_HI;
        end
        S_HI: begin
          lo_part <= mul_prod[PROD_W-1:DRAW_W];
          state   <= S_TH;
        end
        S_TH: begin
          thresh       <= THRESH_W'(mul_prod) + THRESH_W'(lo_part);
          acc          <= '0;
          scan_addr    <= '0;
          lon_cnt      <= '0;
          lat_cnt      <= '0;
          issue_active <= 1'b1;
          state        <= S_WALK;
        end
        S_WALK: begin
          if (issue_active) begin
            scan_addr <= scan_addr + 1'b1;
            if (lat_cnt == LAT_LAST) begin
              lat_cnt <= '0;
              lon_cnt <= lon_cnt + 1'b1;
            end else begin
              lat_cnt <= lat_cnt + 1'b1;
            end
            if (scan_addr == ADDR_LAST) begin
              issue_active <= 1'b0;
            end
          end
          p1_valid <= issue_active;
          p1_lon   <= lon_cnt;
          p1_lat   <= lat_cnt;
          p1_cos   <= lat_cos(10'(lat_cnt));
          p2_valid <= p1_valid;
          p2_lon   <= p1_lon;
          p2_lat   <= p1_lat;
          p2_index <= ram_rdata[RAM_W-1:STORE_W];
          if (p2_valid) begin
            acc <= acc_sum;
          end
          if (crossed) begin
            res.lon_deg      <= 9'(p2_lon) - LON_OFFSET;
            res.lat_deg      <= 8'(p2_lat) - LAT_OFFSET;
            res.chosen_index <= p2_index;
            res.map_empty    <= 1'b0;
            issue_active     <= 1'b0;
            p1_valid         <= 1'b0;
            p2_valid         <= 1'b0;
            state            <= S_DONE;
          end else if (!issue_active && !p1_valid && !p2_valid) begin
            // Walk ran off the end of the grid without a crossing.
            res   <= '{lon_deg: '0, lat_deg: '0, chosen_index: '0, map_empty: 1'b1};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result.ready) begin
            result_q     <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  smws_ram #(
    .WIDTH (RAM_W),
    .DEPTH (GRID)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smws_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  // The block goes busy right after it takes an item.
  `SMWS_ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  // The product stage only fills from a valid read stage.
  `SMWS_ASSERT_IMPL(a_walk_pipe_order, clk, rst, p2_valid, $past(p1_valid))
  // No result can exist while the RAM is still being cleared.
  `SMWS_ASSERT_IMPL(a_no_result_in_clear, clk, rst, state == S_CLEAR, !result.valid)
  // Walk pipeline activity is confined to the walk state.
  `SMWS_ASSERT_IMPL(a_walk_confined, clk, rst, issue_active || p1_valid || p2_valid, state == S_WALK)

endmodule

`default_nettype wire
